/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is high.
`define RLT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds through reset.
`define RLT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/rlt_pkg.sv */
// ---------------------------------------------------------------------------
// rlt_pkg
// Shared constants, codes and controller/datapath interface types for the
// ratio learning table.
// ---------------------------------------------------------------------------
package rlt_pkg;

  localparam int SLOTS        = 16;
  localparam int IDX_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W        = $clog2(SLOTS + 1);

  localparam int RATIO_W      = 20;
  localparam int WIDTH_W      = 16;
  localparam int TOL_W        = 16;
  localparam int VERDICT_W    = 2;
  localparam int SLOT_INDEX_W = 4;

  // floor(x / 100) for 16-bit x as (x * 83887) >> 23, exact over the range
  localparam int DIV_MUL_W    = 17;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL = 17'd83887;
  localparam int DIV_SHIFT    = 23;
  localparam int Q_W          = WIDTH_W + DIV_MUL_W - DIV_SHIFT;

  // APB register map
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;
  localparam logic REG_RATIO_TOLERANCE = 1'b0;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd50;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_NEW       = 2'd0,
    VERDICT_SAME      = 2'd1,
    VERDICT_CONFIRMED = 2'd2,
    VERDICT_NO_SLOT   = 2'd3
  } verdict_t;

  typedef struct packed {
    logic load;     // latch the request, start reading slot 0
    logic scan;     // step the read address
    logic capture;  // hold the matching slot
    logic alloc;    // end of scan without a match
    logic update;   // write back the matched slot
    logic publish;  // move the pending answer to the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic match;    // slot under compare is filled and both ratios match
    logic last;     // slot under compare is the last filled one (or none)
  } dp_status_t;

endpackage

/* hdl/rlt_ctrl.sv */
// ---------------------------------------------------------------------------
// rlt_ctrl
// Sequencer for one request: scan, evaluate the hit, hand over the answer.
// ---------------------------------------------------------------------------
module rlt_ctrl import rlt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_EVAL = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.match) begin
          cmd.capture = 1'b1;
          state_next  = S_EVAL;
        end else if (status.last) begin
          cmd.alloc  = 1'b1;
          state_next = S_RESP;
        end
      end
      S_EVAL: begin
        cmd.update = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        // wait until the output register is free
        if (!out_valid || out_ready) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.publish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* hdl/rlt_dp.sv */
// ---------------------------------------------------------------------------
// rlt_dp
// Slot memories, ratio compare, width check and the answer registers.
// ---------------------------------------------------------------------------
module rlt_dp import rlt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  ctrl_cmd_t               cmd,
  output dp_status_t              status,
  input  logic [TOL_W-1:0]        tolerance,
  input  logic [RATIO_W-1:0]      ratio_w,
  input  logic [RATIO_W-1:0]      ratio_h,
  input  logic [WIDTH_W-1:0]      internal_width,
  output logic [VERDICT_W-1:0]    verdict,
  output logic [SLOT_INDEX_W-1:0] slot_index
);

  function automatic logic within_ratio(input logic [RATIO_W-1:0] a,
                                        input logic [RATIO_W-1:0] b,
                                        input logic [TOL_W-1:0]   tol);
    logic [RATIO_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d <= RATIO_W'(tol);
  endfunction

  // request
  logic [RATIO_W-1:0] obs_w, obs_h;
  logic [WIDTH_W-1:0] obs_iw;

  // slot stores: {ratio_w, ratio_h} and {confirmed, last_width}
  logic [2*RATIO_W-1:0] ratio_mem [SLOTS];
  logic [WIDTH_W:0]     width_mem [SLOTS];
  logic [2*RATIO_W-1:0] rd_ratio;
  logic [WIDTH_W:0]     rd_width;

  logic [IDX_W-1:0] scan_idx, scan_idx_next, cmp_idx;
  logic [CNT_W-1:0] slot_count;

  logic [IDX_W-1:0]   hit_idx;
  logic               hit_conf;
  logic [WIDTH_W-1:0] hit_lw;
  logic [Q_W-1:0]     hit_q;

  verdict_t         pend_verdict;
  logic [IDX_W-1:0] pend_idx;

  logic                       in_table, full, width_ok;
  logic [WIDTH_W+DIV_MUL_W-1:0] lw_prod;
  logic [WIDTH_W-1:0]         wdiff, wlimit;
  logic                       ratio_we, width_we;
  logic [IDX_W-1:0]           width_waddr;
  logic [WIDTH_W:0]           width_wdata;
  logic [IDX_W-1:0]           alloc_idx;

  assign in_table  = CNT_W'(cmp_idx) < slot_count;
  assign full      = (slot_count == CNT_W'(SLOTS));
  assign alloc_idx = slot_count[IDX_W-1:0];

  assign status.match = in_table
                      && within_ratio(obs_w, rd_ratio[2*RATIO_W-1:RATIO_W], tolerance)
                      && within_ratio(obs_h, rd_ratio[RATIO_W-1:0], tolerance);
  assign status.last  = (CNT_W'(cmp_idx) + CNT_W'(1)) >= slot_count;

  // last_width / 100 by reciprocal
  assign lw_prod = rd_width[WIDTH_W-1:0] * DIV_MUL;

  assign wdiff    = (obs_iw > hit_lw) ? (obs_iw - hit_lw) : (hit_lw - obs_iw);
  assign wlimit   = WIDTH_W'(hit_q) + WIDTH_W'(1);
  assign width_ok = wdiff <= wlimit;

  assign ratio_we    = cmd.alloc && !full;
  assign width_we    = ratio_we || cmd.update;
  assign width_waddr = cmd.update ? hit_idx : alloc_idx;
  assign width_wdata = {cmd.update && (hit_conf || !width_ok), obs_iw};

  always_comb begin
    scan_idx_next = '0;
    if (cmd.load) begin
      scan_idx_next = IDX_W'(1);
    end else if (cmd.scan) begin
      scan_idx_next = scan_idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ratio_we) begin
      ratio_mem[alloc_idx] <= {obs_w, obs_h};
    end
    if (width_we) begin
      width_mem[width_waddr] <= width_wdata;
    end
    rd_ratio <= ratio_mem[scan_idx];
    rd_width <= width_mem[scan_idx];
    cmp_idx  <= scan_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      slot_count <= '0;
    end else begin
      scan_idx <= scan_idx_next;
      if (ratio_we) begin
        slot_count <= slot_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      obs_w  <= ratio_w;
      obs_h  <= ratio_h;
      obs_iw <= internal_width;
    end
    if (cmd.capture) begin
      hit_idx  <= cmp_idx;
      hit_conf <= rd_width[WIDTH_W];
      hit_lw   <= rd_width[WIDTH_W-1:0];
      hit_q    <= lw_prod[DIV_SHIFT+Q_W-1:DIV_SHIFT];
    end
    if (cmd.alloc) begin
      if (full) begin
        pend_verdict <= VERDICT_NO_SLOT;
        pend_idx     <= '0;
      end else begin
        pend_verdict <= VERDICT_NEW;
        pend_idx     <= alloc_idx;
      end
    end
    if (cmd.update) begin
      pend_idx <= hit_idx;
      if (hit_conf || !width_ok) begin
        pend_verdict <= VERDICT_CONFIRMED;
      end else begin
        pend_verdict <= VERDICT_SAME;
      end
    end
    if (cmd.publish) begin
      verdict    <= pend_verdict;
      slot_index <= SLOT_INDEX_W'(pend_idx);
    end
  end

endmodule

/* hdl/ratio_learning_table_unit.sv */
// ---------------------------------------------------------------------------
// ratio_learning_table_unit
// Learns display ratio slots and classifies each observation against them.
//
//   channel  direction  handshake           payload
//   in       request    in_valid/in_ready   ratio_w, ratio_h, internal_width
//   out      result     out_valid/out_ready verdict, slot_index
//   cfg      APB write  psel/penable/pwrite paddr, pwdata (prdata on read)
//
// A request goes through load, the slot scan, an evaluate step on a hit and the
// response step. The scan reads up to the matching slot, or every filled slot (at
// least one) on a miss, one slot per cycle from the slot memory.
// Reset clears the slot count and the tolerance (to 50); no clearing pass.
// A new request is taken while a finished result still waits on out_ready.
// ---------------------------------------------------------------------------
module ratio_learning_table_unit import rlt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [RATIO_W-1:0]      ratio_w,
  input  logic [RATIO_W-1:0]      ratio_h,
  input  logic [WIDTH_W-1:0]      internal_width,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [VERDICT_W-1:0]    verdict,
  output logic [SLOT_INDEX_W-1:0] slot_index,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [PDATA_W-1:0]      pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  logic [TOL_W-1:0] ratio_tolerance;
  logic             reg_sel;
  ctrl_cmd_t        cmd;
  dp_status_t       status;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_RATIO_TOLERANCE);
  assign prdata  = reg_sel ? PDATA_W'(ratio_tolerance) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_tolerance <= TOL_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      ratio_tolerance <= pwdata[TOL_W-1:0];
    end
  end

  rlt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rlt_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .tolerance      (ratio_tolerance),
    .ratio_w        (ratio_w),
    .ratio_h        (ratio_h),
    .internal_width (internal_width),
    .verdict        (verdict),
    .slot_index     (slot_index)
  );

endmodule

/* hdl/rlt_checker.sv */
// ---------------------------------------------------------------------------
// rlt_checker
// Port-level checks on the ratio learning table, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rlt_checker import rlt_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [VERDICT_W-1:0]    verdict,
  input logic [SLOT_INDEX_W-1:0] slot_index
);

  `RLT_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(slot_index), "result dropped or changed while stalled")

  `RLT_ASSERT(a_no_slot_zero, clk, rst, out_valid && (verdict == VERDICT_NO_SLOT) |-> slot_index == '0, "no-slot answer with nonzero index")

  // a request is processed alone: ready drops right after acceptance
  `RLT_ASSERT(a_one_request, clk, rst, in_valid && in_ready |=> !in_ready, "second request taken during a scan")

  `RLT_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid && in_ready, "not idle after reset")

endmodule

bind ratio_learning_table_unit rlt_checker u_rlt_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .verdict    (verdict),
  .slot_index (slot_index)
);

/* tb/ratio_learning_table_unit_test.sv */
// ---------------------------------------------------------------------------
// ratio_learning_table_unit_test
// Self-checking bench for the ratio learning table. A tracking model of the
// slot table classifies every accepted request, and the verdict and slot
// index that come out are checked in order. The tolerance is stepped through
// several values, including both ends of its range. Requests mostly land
// near learned slots, with fresh ratios mixed in that fill the table up.
// ---------------------------------------------------------------------------
module ratio_learning_table_unit_test;
  import rlt_pkg::*;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio_w;
    logic [RATIO_W-1:0] ratio_h;
    logic [WIDTH_W-1:0] width;
  } observation_t;

  typedef struct packed {
    verdict_t                verdict;
    logic [SLOT_INDEX_W-1:0] slot;
  } answer_t;

  localparam int RATIO_MAX     = (1 << RATIO_W) - 1;
  localparam int WIDTH_MAX     = (1 << WIDTH_W) - 1;
  localparam int SETTLE_CYCLES = 25;
  localparam int LONG_HOLD     = 300;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 56;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [RATIO_W-1:0]      ratio_w = '0;
  logic [RATIO_W-1:0]      ratio_h = '0;
  logic [WIDTH_W-1:0]      internal_width = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [VERDICT_W-1:0]    verdict;
  logic [SLOT_INDEX_W-1:0] slot_index;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [PADDR_W-1:0]      paddr = '0;
  logic [PDATA_W-1:0]      pwdata = '0;
  logic [PDATA_W-1:0]      prdata;
  logic                    pready;

  ratio_learning_table_unit u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // tracking copy of the slot table
  logic [RATIO_W-1:0] slot_ratio_w [SLOTS];
  logic [RATIO_W-1:0] slot_ratio_h [SLOTS];
  logic [WIDTH_W-1:0] slot_width [SLOTS];
  logic               slot_confirmed [SLOTS];
  int                 filled_slots = 0;
  int                 tolerance = int'(TOL_RESET);

  observation_t obs_pending [$];
  answer_t      verdict_due [$];
  observation_t next_obs;
  int           queued_cnt = 0;
  int           accepted_cnt = 0;
  int           fail_cnt = 0;
  int           verdict_seen [4] = '{0, 0, 0, 0};
  int           tol_settings = 1;

  int burst_left = 0;
  int gap_left = 0;
  int max_gap = 3;
  int stall_pct = 20;
  int hold_left = 0;
  logic hold_request = 1'b0;
  logic hold_taken = 1'b0;

  function automatic bit within_span(int a, int b, int span);
    return ((a > b) ? a - b : b - a) <= span;
  endfunction

  function automatic answer_t classify_observation(observation_t obs);
    answer_t ans;
    bit      hit;
    ans.verdict = VERDICT_NO_SLOT;
    ans.slot = '0;
    hit = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!hit && i < filled_slots &&
          within_span(obs.ratio_w, slot_ratio_w[i], tolerance) &&
          within_span(obs.ratio_h, slot_ratio_h[i], tolerance)) begin
        hit = 1'b1;
        ans.slot = SLOT_INDEX_W'(i);
        if (slot_confirmed[i]) begin
          ans.verdict = VERDICT_CONFIRMED;
        end else if (within_span(obs.width, slot_width[i], slot_width[i] / 100 + 1)) begin
          ans.verdict = VERDICT_SAME;
        end else begin
          slot_confirmed[i] = 1'b1;
          ans.verdict = VERDICT_CONFIRMED;
        end
        slot_width[i] = obs.width;
      end
    end
    if (!hit && filled_slots < SLOTS) begin
      slot_ratio_w[filled_slots] = obs.ratio_w;
      slot_ratio_h[filled_slots] = obs.ratio_h;
      slot_width[filled_slots] = obs.width;
      slot_confirmed[filled_slots] = 1'b0;
      ans.verdict = VERDICT_NEW;
      ans.slot = SLOT_INDEX_W'(filled_slots);
      filled_slots++;
    end
    return ans;
  endfunction

  // mostly inside the span, sometimes just past its edge
  function automatic int near_value(int base, int span, int top);
    int off;
    int v;
    off = ($urandom_range(0, 4) == 0) ? span + $urandom_range(1, 2) : $urandom_range(0, span);
    v = $urandom_range(0, 1) ? base + off : base - off;
    if (v < 0) v = 0;
    if (v > top) v = top;
    return v;
  endfunction

  function automatic observation_t make_observation();
    observation_t obs;
    int           pick;
    int           w;
    if (filled_slots != 0 && $urandom_range(0, 9) < 7) begin
      pick = $urandom_range(0, filled_slots - 1);
      w = slot_width[pick];
      obs.ratio_w = RATIO_W'(near_value(slot_ratio_w[pick], tolerance, RATIO_MAX));
      obs.ratio_h = RATIO_W'(near_value(slot_ratio_h[pick], tolerance, RATIO_MAX));
      obs.width = ($urandom_range(0, 9) < 6) ? WIDTH_W'(near_value(w, w / 100 + 1, WIDTH_MAX))
                                             : WIDTH_W'($urandom);
    end else begin
      obs.ratio_w = $urandom_range(0, 1) ? RATIO_W'($urandom) : RATIO_W'($urandom_range(0, 30000));
      obs.ratio_h = $urandom_range(0, 1) ? RATIO_W'($urandom) : RATIO_W'($urandom_range(0, 30000));
      obs.width = WIDTH_W'($urandom);
    end
    return obs;
  endfunction

  task automatic queue_obs(int rw, int rh, int iw);
    obs_pending.push_back({RATIO_W'(rw), RATIO_W'(rh), WIDTH_W'(iw)});
    queued_cnt++;
  endtask

  task automatic wait_drained();
    while (accepted_cnt != queued_cnt || verdict_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(int value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({REG_RATIO_TOLERANCE, 2'b00});
    pwdata <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tolerance = value;
    tol_settings++;
  endtask

  // request driver: bursts with random gaps in between
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (obs_pending.size() != 0) begin
        next_obs = obs_pending.pop_front();
        in_valid <= 1'b1;
        ratio_w <= next_obs.ratio_w;
        ratio_h <= next_obs.ratio_h;
        internal_width <= next_obs.width;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left <= (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result sink: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_taken <= 1'b0;
    end else if (hold_request && !hold_taken) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_taken <= 1'b1;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    answer_t due;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (verdict_due.size() == 0) begin
          $error("result with no request pending: verdict %0d slot_index %0d",
                 verdict, slot_index);
          fail_cnt++;
        end else begin
          due = verdict_due.pop_front();
          verdict_seen[verdict]++;
          if (verdict !== due.verdict) begin
            $error("verdict: expected %0d, got %0d", due.verdict, verdict);
            fail_cnt++;
          end
          if (slot_index !== due.slot) begin
            $error("slot_index: expected %0d, got %0d", due.slot, slot_index);
            fail_cnt++;
          end
        end
      end
      if (in_valid && in_ready) begin
        verdict_due.push_back(classify_observation({ratio_w, ratio_h, internal_width}));
        accepted_cnt++;
      end
    end
  end

  initial begin
    int phase_tol [PHASES];
    int phase_stall [PHASES];
    int phase_gap [PHASES];
    phase_tol = '{0, 1000, 65535, 50, -1, -1, 25};
    phase_stall = '{0, 30, 10, 70, 50, 0, 90};
    phase_gap = '{0, 8, 0, 20, 4, 0, 12};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset tolerance of 50: edges of the ratio and width windows
    queue_obs(0, 0, 0);
    queue_obs(0, 0, 0);
    queue_obs(50, 50, 1);
    queue_obs(51, 0, 1);
    queue_obs(0, 0, 100);
    queue_obs(0, 0, 7);
    queue_obs(RATIO_MAX, RATIO_MAX, WIDTH_MAX);
    queue_obs(RATIO_MAX, RATIO_MAX - 50, WIDTH_MAX - 656);
    queue_obs(RATIO_MAX - 51, RATIO_MAX, 0);
    queue_obs(101, 0, 1);
    queue_obs(101, 0, 3);
    queue_obs(RATIO_MAX, RATIO_MAX, 0);
    queue_obs(20'hAAAAA, 20'h55555, 16'hAAAA);
    queue_obs(20'h55555, 20'hAAAAA, 16'h5555);
    queue_obs(20'hAAAAA, 20'h55555, 16'hAAAA);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      write_tolerance((phase_tol[p] < 0) ? $urandom_range(0, 4000) : phase_tol[p]);
      stall_pct = phase_stall[p];
      max_gap = phase_gap[p];
      // sender keeps offering while the sink holds off; fills the block
      if (p == 2) hold_request <= 1'b1;
      repeat (PHASE_ITEMS) obs_pending.push_back(make_observation());
      queued_cnt += PHASE_ITEMS;
      wait_drained();
    end

    $display("covered %0d requests over %0d tolerance settings, %0d of %0d slots filled",
             accepted_cnt, tol_settings, filled_slots, SLOTS);
    $display("verdicts: new %0d, same session %0d, confirmed %0d, no slot %0d",
             verdict_seen[VERDICT_NEW], verdict_seen[VERDICT_SAME],
             verdict_seen[VERDICT_CONFIRMED], verdict_seen[VERDICT_NO_SLOT]);
    if (fail_cnt == 0) begin
      $display("PASS ratio_learning_table_unit");
    end else begin
      $display("FAIL ratio_learning_table_unit");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL ratio_learning_table_unit");
    $finish;
  end

endmodule
